/* sv/dlrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlrp_pkg;

	// Input item kinds as they arrive on the kind port.
	localparam logic [2:0] KIND_PAD   = 3'd0;
	localparam logic [2:0] KIND_TICK  = 3'd1;
	localparam logic [2:0] KIND_REC   = 3'd2;
	localparam logic [2:0] KIND_PLAY  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	// Operations after classification by the front end.
	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_PAD   = 3'd1;
	localparam logic [2:0] OP_TICK  = 3'd2;
	localparam logic [2:0] OP_REC   = 3'd3;
	localparam logic [2:0] OP_PLAY  = 3'd4;
	localparam logic [2:0] OP_CLEAR = 3'd5;

	// Configuration register indexes and their reset values.
	localparam logic CFG_HIT_WINDOW = 1'b0;
	localparam logic CFG_TICK_STEP  = 1'b1;
	localparam logic [15:0] HIT_WINDOW_RESET = 16'd5000;
	localparam logic [15:0] TICK_STEP_RESET  = 16'd1000;

	localparam int PAD_W  = 3;
	localparam int TIME_W = 32;
	localparam int NOW_W  = 48;

	typedef struct packed {
		logic [2:0]       op;
		logic [PAD_W-1:0] pad;
		logic [NOW_W-1:0] now_us;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/dlrp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlrp_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/dlrp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlrp_front import dlrp_pkg::*; #(
	parameter int PAD_COUNT = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [2:0]       kind,
	input  wire logic [PAD_W-1:0] pad,
	input  wire logic [NOW_W-1:0] now_us,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	input  wire logic             cmd_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	cmd_t       cls;

	// A pad hit on a pad that does not exist, and any unknown kind, leave
	// the state alone, so both are carried as a no-op.
	always_comb begin
		cls.pad    = pad;
		cls.now_us = now_us;
		case (kind)
			KIND_PAD: begin
				cls.op = ({29'd0, pad} < PAD_COUNT) ? OP_PAD : OP_NOP;
			end
			KIND_TICK:  cls.op = OP_TICK;
			KIND_REC:   cls.op = OP_REC;
			KIND_PLAY:  cls.op = OP_PLAY;
			KIND_CLEAR: cls.op = OP_CLEAR;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/dlrp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlrp_back import dlrp_pkg::*; #(
	parameter int EVENT_SLOTS = 64,
	parameter int PAD_COUNT = 5,
	localparam int TW = $clog2(EVENT_SLOTS + 1),
	localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [15:0]          hit_window_us,
	input  wire logic [15:0]          tick_step_us,
	input  wire logic                 cmd_valid,
	input  wire cmd_t                 cmd,
	output logic                      cmd_pop,
	output logic                      empty,
	input  wire logic                 pop,
	output logic      [PAD_COUNT-1:0] trigger_mask,
	output logic                      recording,
	output logic                      playing,
	output logic      [TW-1:0]        stored_events,
	output logic      [TIME_W-1:0]    position_us
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WIN  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam int EW = PAD_W + TIME_W;
	localparam logic [TW-1:0] SLOTS = TW'(EVENT_SLOTS);

	logic [1:0]           state_q;
	logic                 rec_q;
	logic                 play_q;
	logic [TW-1:0]        total_q;
	logic [NOW_W-1:0]     start_q;
	logic [TIME_W-1:0]    loop_q;
	logic [TIME_W-1:0]    pos_q;
	logic [PAD_COUNT-1:0] mask_q;
	logic [TIME_W-1:0]    lo_q;
	logic                 clamp_q;
	logic [TW-1:0]        idx_q;
	logic                 rd_v_s1;

	logic [NOW_W-1:0]     diff;
	logic [TIME_W-1:0]    elapsed;
	logic [TIME_W:0]      pos_sum;
	logic [TIME_W-1:0]    pos_step;
	logic                 ram_we;
	logic [EW-1:0]        ram_rdata;
	logic [TIME_W-1:0]    ev_time;
	logic [PAD_W-1:0]     ev_pad;
	logic                 ev_hit;
	logic [PAD_COUNT-1:0] ev_mask;
	logic [PAD_COUNT-1:0] cmd_mask;
	logic                 issue;
	logic                 emit;

	// Output queue of two results.
	logic [PAD_COUNT-1:0] oq_mask_q [2];
	logic                 oq_rec_q [2];
	logic                 oq_play_q [2];
	logic [TW-1:0]        oq_total_q [2];
	logic [TIME_W-1:0]    oq_pos_q [2];
	logic                 oq_wr_q;
	logic                 oq_rd_q;
	logic [1:0]           oq_cnt_q;
	logic                 oq_pop;

	// Offset from record start on a wrapping 48-bit timer, saturated to 32 bits.
	assign diff    = cmd.now_us - start_q;
	assign elapsed = (|diff[NOW_W-1:TIME_W]) ? '1 : diff[TIME_W-1:0];

	assign pos_sum  = {1'b0, pos_q} + {17'd0, tick_step_us};
	assign pos_step = pos_sum[TIME_W] ? '1 : pos_sum[TIME_W-1:0];

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid && (oq_cnt_q != 2'd2);
	assign ram_we  = cmd_pop && (cmd.op == OP_PAD) && rec_q && (total_q < SLOTS);
	assign issue   = (idx_q < total_q);
	assign emit    = (state_q == ST_EMIT);

	assign ev_time = ram_rdata[TIME_W-1:0];
	assign ev_pad  = ram_rdata[EW-1:TIME_W];
	assign ev_hit  = (ev_time <= pos_q) && (clamp_q || (ev_time > lo_q));

	always_comb begin
		for (int j = 0; j < PAD_COUNT; j++) begin
			ev_mask[j]  = (ev_pad == PAD_W'(j));
			cmd_mask[j] = (cmd.pad == PAD_W'(j));
		end
	end

	dlrp_ram #(
		.WIDTH(EW),
		.DEPTH(EVENT_SLOTS)
	) u_events (
		.clk  (clk),
		.we   (ram_we),
		.waddr(total_q[AW-1:0]),
		.wdata({cmd.pad, elapsed}),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rec_q   <= 1'b0;
			play_q  <= 1'b0;
			total_q <= '0;
			start_q <= '0;
			loop_q  <= '0;
			pos_q   <= '0;
			mask_q  <= '0;
			lo_q    <= '0;
			clamp_q <= 1'b0;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						mask_q  <= (cmd.op == OP_PAD) ? cmd_mask : '0;
						state_q <= ((cmd.op == OP_TICK) && play_q && (loop_q != '0)) ?
							ST_WIN : ST_EMIT;
						case (cmd.op)
							OP_PAD: begin
								if (ram_we) begin
									total_q <= total_q + TW'(1);
								end
							end
							OP_TICK: begin
								if (play_q && (loop_q != '0)) begin
									pos_q <= pos_step;
								end
							end
							OP_REC: begin
								if (!rec_q) begin
									rec_q   <= 1'b1;
									start_q <= cmd.now_us;
									total_q <= '0;
								end else begin
									rec_q  <= 1'b0;
									loop_q <= elapsed;
									if (total_q != '0) begin
										play_q <= 1'b1;
										pos_q  <= '0;
									end
								end
							end
							OP_PLAY: begin
								play_q <= !play_q;
								if (!play_q) begin
									pos_q <= '0;
								end
							end
							OP_CLEAR: begin
								total_q <= '0;
								loop_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WIN: begin
					// Below the window width the lower bound sits at zero.
					clamp_q <= (pos_q < {16'd0, hit_window_us});
					lo_q    <= pos_q - {16'd0, hit_window_us};
					idx_q   <= '0;
					rd_v_s1 <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_v_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + TW'(1);
					end
					if (rd_v_s1 && ev_hit) begin
						mask_q <= mask_q | ev_mask;
					end
					if (!issue && !rd_v_s1) begin
						if (pos_q >= loop_q) begin
							pos_q <= '0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty  = (oq_cnt_q == 2'd0);
	assign oq_pop = pop && !empty;

	assign trigger_mask  = oq_mask_q[oq_rd_q];
	assign recording     = oq_rec_q[oq_rd_q];
	assign playing       = oq_play_q[oq_rd_q];
	assign stored_events = oq_total_q[oq_rd_q];
	assign position_us   = oq_pos_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			oq_mask_q[oq_wr_q]  <= mask_q;
			oq_rec_q[oq_wr_q]   <= rec_q;
			oq_play_q[oq_wr_q]  <= play_q;
			oq_total_q[oq_wr_q] <= total_q;
			oq_pos_q[oq_wr_q]   <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (emit) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			case ({emit, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	// A result beat is only produced when the queue had room for it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (oq_cnt_q != 2'd2))
		else $error("result written into a full output queue");

	// The event count never passes the table size.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= SLOTS)
		else $error("event count beyond table size");

	// Two commands are never taken back to back.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !cmd_pop)
		else $error("two commands taken back to back");

	// A scan leaves the play position inside the loop.
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && !issue && !rd_v_s1) |=> (pos_q < loop_q))
		else $error("play position not wrapped after scan");

endmodule

`default_nettype wire

/* sv/drum_loop_recorder_player_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Beat contents
// input     push / full           kind, pad, now_us
// result    pop / empty           trigger_mask, recording, playing, stored_events, position_us
// config    cfg_wr_en             cfg_index, cfg_wdata
//
// A tick while playing with a non-zero loop length passes from idle through
// the window, scan and emit states in the back end: the event table is one RAM
// with one read port, scanned one entry per cycle. Every other item goes from
// idle straight to emit in the back end. Reset clears all control state and the config
// registers; the event table holds no reset and needs no clearing pass.
// A two-beat queue on each side lets input and result stall independently.

module drum_loop_recorder_player_unit import dlrp_pkg::*; #(
	parameter int EVENT_SLOTS = 64,
	parameter int PAD_COUNT = 5,
	localparam int TW = $clog2(EVENT_SLOTS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [2:0]           kind,
	input  wire logic [PAD_W-1:0]     pad,
	input  wire logic [NOW_W-1:0]     now_us,
	output logic                      empty,
	input  wire logic                 pop,
	output logic      [PAD_COUNT-1:0] trigger_mask,
	output logic                      recording,
	output logic                      playing,
	output logic      [TW-1:0]        stored_events,
	output logic      [TIME_W-1:0]    position_us,
	input  wire logic                 cfg_wr_en,
	input  wire logic                 cfg_index,
	input  wire logic [15:0]          cfg_wdata
);

	logic [15:0] hit_window_q;
	logic [15:0] tick_step_q;
	logic        cmd_valid;
	cmd_t        cmd;
	logic        cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_window_q <= HIT_WINDOW_RESET;
			tick_step_q  <= TICK_STEP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_HIT_WINDOW: hit_window_q <= cfg_wdata;
				CFG_TICK_STEP:  tick_step_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	dlrp_front #(
		.PAD_COUNT(PAD_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.pad      (pad),
		.now_us   (now_us),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	dlrp_back #(
		.EVENT_SLOTS(EVENT_SLOTS),
		.PAD_COUNT  (PAD_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.hit_window_us(hit_window_q),
		.tick_step_us (tick_step_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.empty        (empty),
		.pop          (pop),
		.trigger_mask (trigger_mask),
		.recording    (recording),
		.playing      (playing),
		.stored_events(stored_events),
		.position_us  (position_us)
	);

endmodule

`default_nettype wire

/* bench/dlrp_tb_pkg.sv */
`timescale 1ns / 1ps

package dlrp_tb_pkg;
	import dlrp_pkg::*;

	localparam int PADS  = 5;
	localparam int SLOTS = 64;

	// Kinds that the block has no use for.
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [PADS-1:0] trigger_mask;
		logic            recording;
		logic            playing;
		logic [6:0]      stored_events;
		logic [31:0]     position_us;
	} beat_t;

	class trigger_scoreboard;
		logic [15:0] window_us;
		logic [15:0] step_us;
		logic [2:0]  pad_of[SLOTS];
		logic [31:0] offset_of[SLOTS];
		int          held;
		bit          rec_on;
		bit          play_on;
		logic [47:0] rec_start;
		logic [31:0] loop_len;
		logic [31:0] pos;
		beat_t       due_beats[$];
		int          failures;

		function new();
			window_us = HIT_WINDOW_RESET;
			step_us = TICK_STEP_RESET;
			held = 0;
			rec_on = 1'b0;
			play_on = 1'b0;
			rec_start = '0;
			loop_len = '0;
			pos = '0;
			failures = 0;
		endfunction

		function void set_register(logic idx, logic [15:0] value);
			if (idx == CFG_HIT_WINDOW)
				window_us = value;
			else
				step_us = value;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		// The timer wraps at 48 bits; the offset then saturates at 32 bits.
		function logic [31:0] offset_since_start(logic [47:0] now);
			logic [47:0] d;
			d = now - rec_start;
			return (d > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
		endfunction

		function logic [PADS-1:0] advance_and_fire();
			logic [32:0]     sum;
			logic [PADS-1:0] fired;
			logic            hit;
			int              i;
			fired = '0;
			sum = {1'b0, pos} + {17'b0, step_us};
			pos = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			for (i = 0; i < held; i++) begin
				hit = offset_of[i] <= pos;
				if (pos >= {16'b0, window_us} && offset_of[i] <= pos - {16'b0, window_us})
					hit = 1'b0;
				if (hit)
					fired[pad_of[i]] = 1'b1;
			end
			if (pos >= loop_len)
				pos = '0;
			return fired;
		endfunction

		function void take_input(logic [2:0] kind, logic [2:0] pad, logic [47:0] now);
			beat_t           b;
			logic [PADS-1:0] fired;
			fired = '0;
			case (kind)
				KIND_PAD: begin
					if (pad < PADS) begin
						fired[pad] = 1'b1;
						if (rec_on && held < SLOTS) begin
							pad_of[held] = pad;
							offset_of[held] = offset_since_start(now);
							held++;
						end
					end
				end
				KIND_TICK: begin
					if (play_on && loop_len != 0)
						fired = advance_and_fire();
				end
				KIND_REC: begin
					if (!rec_on) begin
						rec_on = 1'b1;
						rec_start = now;
						held = 0;
					end else begin
						rec_on = 1'b0;
						loop_len = offset_since_start(now);
						if (held > 0) begin
							play_on = 1'b1;
							pos = '0;
						end
					end
				end
				KIND_PLAY: begin
					play_on = !play_on;
					if (play_on)
						pos = '0;
				end
				KIND_CLEAR: begin
					held = 0;
					loop_len = '0;
				end
				default: ;
			endcase
			b.trigger_mask = fired;
			b.recording = rec_on;
			b.playing = play_on;
			b.stored_events = 7'(held);
			b.position_us = pos;
			due_beats.push_back(b);
		endfunction

		task report_mismatch(string what, logic [31:0] want, logic [31:0] seen);
			failures++;
			$display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, seen);
		endtask

		task check_beat(beat_t got);
			beat_t want;
			if (due_beats.size() == 0) begin
				report_mismatch("beat with nothing due", '0, got.position_us);
				return;
			end
			want = due_beats.pop_front();
			if (got.trigger_mask !== want.trigger_mask)
				report_mismatch("trigger_mask", want.trigger_mask, got.trigger_mask);
			if (got.recording !== want.recording)
				report_mismatch("recording", want.recording, got.recording);
			if (got.playing !== want.playing)
				report_mismatch("playing", want.playing, got.playing);
			if (got.stored_events !== want.stored_events)
				report_mismatch("stored_events", want.stored_events, got.stored_events);
			if (got.position_us !== want.position_us)
				report_mismatch("position_us", want.position_us, got.position_us);
		endtask
	endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import dlrp_pkg::*;
	import dlrp_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400_000;
	// A full-table tick plus both two-beat queues, with room to spare.
	localparam int SETTLE_CYCLES = 100;
	localparam int SAT_TICKS     = 24;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [2:0]        kind = '0;
	logic [PAD_W-1:0]  pad = '0;
	logic [NOW_W-1:0]  now_us = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [PADS-1:0]   trigger_mask;
	logic              recording;
	logic              playing;
	logic [6:0]        stored_events;
	logic [TIME_W-1:0] position_us;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_index = 1'b0;
	logic [15:0]       cfg_wdata = '0;

	trigger_scoreboard sb;
	bit                no_idle = 1'b0;
	int                send_run = 0;
	int                recv_run = 0;
	int                cycle_count = 0;

	drum_loop_recorder_player_unit u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly a random wait per beat, broken by stretches with no waiting at all.
	function automatic int draw_gap(inout int run_left);
		if (no_idle)
			return 0;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic logic [47:0] any_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic send_item(input logic [2:0] k, input logic [2:0] p, input logic [47:0] t);
		int gap;
		gap = draw_gap(send_run);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		pad <= p;
		now_us <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.take_input(k, p, t);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic run_directed();
		send_item(KIND_TICK, 3'd0, 48'd0);
		send_item(KIND_PAD, 3'd0, 48'd10);
		send_item(KIND_PAD, 3'd4, 48'd20);
		send_item(KIND_PAD, 3'd5, 48'd30);
		send_item(KIND_SPARE_LO, 3'd1, 48'hFFFF_FFFF_FFFF);
		send_item(KIND_SPARE_HI, 3'd7, 48'd0);
		send_item(KIND_PLAY, 3'd0, 48'd40);
		// Playing with no loop length: the tick must leave everything alone.
		send_item(KIND_TICK, 3'd0, 48'd50);
		send_item(KIND_PLAY, 3'd0, 48'd60);
		// Recording across the wrap of the 48-bit timer.
		send_item(KIND_REC, 3'd0, 48'hFFFF_FFFF_F000);
		send_item(KIND_PAD, 3'd1, 48'hFFFF_FFFF_F000);
		send_item(KIND_PAD, 3'd2, 48'h0000_0000_0800);
		send_item(KIND_PAD, 3'd7, 48'h0000_0000_0900);
		send_item(KIND_PAD, 3'd3, 48'h0000_0000_1000);
		send_item(KIND_REC, 3'd0, 48'h0000_0000_2800);
		// The early ticks fall below the window, where its lower edge is clamped.
		repeat (8) send_item(KIND_TICK, 3'd0, any_time());
		send_item(KIND_CLEAR, 3'd0, 48'd0);
		send_item(KIND_PLAY, 3'd0, 48'd0);
		send_item(KIND_REC, 3'd0, 48'd100);
		send_item(KIND_REC, 3'd0, 48'd900);
	endtask

	task automatic run_random(input int quota, input bit fill_table);
		int          sent;
		int          n;
		int          k;
		int          r;
		logic [47:0] base;
		logic [47:0] off;
		logic [2:0]  p;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 9) < 8) begin
				if (sb.rec_on) begin
					send_item(KIND_REC, 3'($urandom), any_time());
					sent++;
				end
				if ($urandom_range(0, 3) == 0)
					base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 20000));
				else
					base = any_time();
				send_item(KIND_REC, 3'($urandom), base);
				sent++;
				if (fill_table)
					n = $urandom_range(SLOTS, SLOTS + 6);
				else if ($urandom_range(0, 11) == 0)
					n = $urandom_range(SLOTS - 2, SLOTS + 6);
				else
					n = $urandom_range(0, 8);
				fill_table = 1'b0;
				off = '0;
				repeat (n) begin
					off += 48'($urandom_range(0, 2 * sb.step_us));
					if ($urandom_range(0, 29) == 0)
						off += 48'($urandom) << $urandom_range(0, 16);
					if ($urandom_range(0, 9) == 0)
						p = 3'($urandom_range(PADS, 7));
					else
						p = 3'($urandom_range(0, PADS - 1));
					if ($urandom_range(0, 7) == 0) begin
						send_item(KIND_TICK, p, base + off);
						sent++;
					end
					send_item(KIND_PAD, p, base + off);
					sent++;
				end
				off += 48'($urandom_range(1, 2 * sb.step_us));
				send_item(KIND_REC, 3'($urandom), base + off);
				sent++;
				k = $urandom_range(4, 40);
				repeat (k) begin
					r = $urandom_range(0, 15);
					if (r == 0)
						send_item(KIND_PLAY, 3'($urandom), any_time());
					else if (r == 1)
						send_item(KIND_CLEAR, 3'($urandom), any_time());
					else if (r == 2)
						send_item(KIND_PAD, 3'($urandom), any_time());
					else
						send_item(KIND_TICK, 3'($urandom), any_time());
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					k = $urandom_range(0, 7);
					send_item(3'(k), 3'($urandom), any_time());
					if (3'(k) <= KIND_CLEAR)
						sent++;
				end
			end
		end
	endtask

	// One event at the saturated offset and a saturated loop length, then a
	// burst of back-to-back ticks with the largest even step.
	task automatic run_position_clip();
		if (sb.rec_on)
			send_item(KIND_REC, 3'd0, 48'd0);
		send_item(KIND_REC, 3'd0, 48'd0);
		send_item(KIND_PAD, 3'd2, 48'hFFFF_FFFF_FFFF);
		send_item(KIND_REC, 3'd0, 48'h1_0000_0000);
		no_idle = 1'b1;
		repeat (SAT_TICKS) send_item(KIND_TICK, 3'($urandom), any_time());
		no_idle = 1'b0;
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int    gap;
		beat_t got;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(recv_run);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got = '{trigger_mask, recording, playing, stored_events, position_us};
			sb.check_beat(got);
		end
	end

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(125, 1'b1);

		drain();
		write_reg(CFG_HIT_WINDOW, 16'd0);
		write_reg(CFG_TICK_STEP, 16'd1);
		run_random(125, 1'b0);

		drain();
		write_reg(CFG_HIT_WINDOW, 16'hFFFF);
		write_reg(CFG_TICK_STEP, 16'hFFFF);
		run_random(125, 1'b0);

		drain();
		write_reg(CFG_HIT_WINDOW, 16'($urandom));
		write_reg(CFG_TICK_STEP, 16'($urandom_range(1, 16'hFFFF)));
		run_random(125, 1'b0);

		drain();
		write_reg(CFG_HIT_WINDOW, 16'd100);
		write_reg(CFG_TICK_STEP, 16'hFFFE);
		run_position_clip();

		drain();
		if (sb.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
